// ----- src/esc_tfd_pkg.sv -----
// Shared types, constants and the CRC-8 byte update for the telemetry frame decoder.
package esc_tfd_pkg;

	localparam int PAYLOAD_BYTES = 9;
	localparam int FRAME_BYTES   = 10;
	localparam int CNT_W         = 4;
	localparam int TICK_W        = 20;
	localparam int DISC_W        = 16;
	localparam int IDX_W         = $clog2(PAYLOAD_BYTES);

	localparam logic [7:0]        CRC_POLY    = 8'h07;
	localparam logic [7:0]        CRC_TOP     = 8'h80;
	localparam logic [TICK_W-1:0] TICK_MAX    = {TICK_W{1'b1}};
	localparam logic [DISC_W-1:0] DISCARD_MAX = {DISC_W{1'b1}};
	localparam logic [TICK_W-1:0] TIMEOUT_RST = TICK_W'(10000);

	// Request codes
	localparam logic [1:0] REQ_START = 2'd0;
	localparam logic [1:0] REQ_BYTE  = 2'd1;
	localparam logic [1:0] REQ_TICK  = 2'd2;

	// Register index of the timeout register
	localparam logic REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		ST_VALID   = 2'd0,
		ST_CRC_BAD = 2'd1,
		ST_SHORT   = 2'd2
	} status_t;

	typedef struct packed {
		status_t           frame_status;
		logic [7:0]        temperature_c;
		logic [15:0]       voltage_word;
		logic [15:0]       current_word;
		logic [15:0]       consumed_mah;
		logic [15:0]       erpm_word;
		logic [CNT_W-1:0]  bytes_received;
		logic [DISC_W-1:0] discarded_total;
	} result_t;

	// CRC-8, MSB first, one byte
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
		logic [7:0] v;
		v = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if ((v & CRC_TOP) != 8'h00) begin
				v = {v[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

// ----- src/esc_tfd_cfg.sv -----
// APB-style configuration register holding the reply timeout.
module esc_tfd_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [2:0]                       paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output logic [esc_tfd_pkg::TICK_W-1:0]   timeout_ticks
);
	import esc_tfd_pkg::*;

	logic [TICK_W-1:0] timeout_q;
	logic              wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);

	// Write the timeout register on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (wr_en) begin
			timeout_q <= pwdata[TICK_W-1:0];
		end
	end

	// Read back; addresses past the register read zero
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_TIMEOUT) begin
			prdata = {{(32-TICK_W){1'b0}}, timeout_q};
		end
	end

	assign timeout_ticks = timeout_q;

endmodule

// ----- src/esc_tfd_core.sv -----
// Frame state, CRC accumulation, timeout and result formation for one item.
module esc_tfd_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [1:0]                     req_type,
	input  logic [7:0]                     rx_byte,
	input  logic [esc_tfd_pkg::TICK_W-1:0] timeout_ticks,
	output logic                           res_valid,
	output esc_tfd_pkg::result_t           res
);
	import esc_tfd_pkg::*;

	logic              window_open_q;
	logic [CNT_W-1:0]  byte_count_q;
	logic [7:0]        crc_q;
	logic [TICK_W-1:0] tick_count_q;
	logic [DISC_W-1:0] discard_count_q;
	logic [7:0]        frame_buf_q [PAYLOAD_BYTES];

	logic              window_open_d;
	logic [CNT_W-1:0]  byte_count_d;
	logic [7:0]        crc_d;
	logic [TICK_W-1:0] tick_count_d;
	logic [DISC_W-1:0] discard_count_d;
	logic              buf_we;
	logic [TICK_W-1:0] tick_inc;
	logic              with_data;

	assign tick_inc = (tick_count_q < TICK_MAX) ? tick_count_q + 1'b1 : tick_count_q;

	// Next state and result for the current item
	always_comb begin
		window_open_d   = window_open_q;
		byte_count_d    = byte_count_q;
		crc_d           = crc_q;
		tick_count_d    = tick_count_q;
		discard_count_d = discard_count_q;
		buf_we          = 1'b0;
		res_valid       = 1'b0;
		with_data       = 1'b0;
		res.frame_status = ST_SHORT;
		unique case (req_type)
			REQ_START: begin
				window_open_d = 1'b1;
				byte_count_d  = '0;
				crc_d         = 8'h00;
				tick_count_d  = '0;
			end
			REQ_BYTE: begin
				if (!window_open_q) begin
					if (discard_count_q < DISCARD_MAX) begin
						discard_count_d = discard_count_q + 1'b1;
					end
				end else if (byte_count_q < CNT_W'(PAYLOAD_BYTES)) begin
					buf_we       = 1'b1;
					crc_d        = crc8_byte(crc_q, rx_byte);
					byte_count_d = byte_count_q + 1'b1;
				end else begin
					// Check byte closes the frame
					byte_count_d     = CNT_W'(FRAME_BYTES);
					window_open_d    = 1'b0;
					res_valid        = 1'b1;
					with_data        = 1'b1;
					res.frame_status = (rx_byte == crc_q) ? ST_VALID : ST_CRC_BAD;
				end
			end
			REQ_TICK: begin
				if (window_open_q) begin
					tick_count_d = tick_inc;
					if (tick_inc >= timeout_ticks) begin
						window_open_d    = 1'b0;
						res_valid        = 1'b1;
						res.frame_status = ST_SHORT;
					end
				end
			end
			default: begin
			end
		endcase
		res.temperature_c   = with_data ? frame_buf_q[0] : 8'h00;
		res.voltage_word    = with_data ? {frame_buf_q[1], frame_buf_q[2]} : 16'h0000;
		res.current_word    = with_data ? {frame_buf_q[3], frame_buf_q[4]} : 16'h0000;
		res.consumed_mah    = with_data ? {frame_buf_q[5], frame_buf_q[6]} : 16'h0000;
		res.erpm_word       = with_data ? {frame_buf_q[7], frame_buf_q[8]} : 16'h0000;
		res.bytes_received  = byte_count_d;
		res.discarded_total = discard_count_q;
	end

	// Advance control state when the item is consumed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_open_q   <= 1'b0;
			byte_count_q    <= '0;
			crc_q           <= 8'h00;
			tick_count_q    <= '0;
			discard_count_q <= '0;
		end else if (step) begin
			window_open_q   <= window_open_d;
			byte_count_q    <= byte_count_d;
			crc_q           <= crc_d;
			tick_count_q    <= tick_count_d;
			discard_count_q <= discard_count_d;
		end
	end

	// Store payload bytes; no reset, each is written before it is read
	always_ff @(posedge clk) begin
		if (step && buf_we) begin
			frame_buf_q[byte_count_q[IDX_W-1:0]] <= rx_byte;
		end
	end

endmodule

// ----- src/esc_telemetry_frame_decoder_core.sv -----
// Top level of the telemetry frame decoder: input stage, decode core, result register.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------------
//   input     | in_valid / in_ready  | req_type, rx_byte
//   result    | out_valid / out_ready| frame_status, temperature_c, ... words,
//             |                      | bytes_received, discarded_total
//   config    | APB psel/penable     | paddr, pwdata, prdata, pready
//
// One item is taken every cycle unless a held result stalls the input stage; the input stage
// registers each beat, and its result is loaded into the result register when it advances (single decode pass).
// Reset (arst_n low) closes the window, clears counts and CRC, and sets the timeout to 10000.
// A held result stalls the input stage only when a new result would need the register.
module esc_telemetry_frame_decoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  frame_status,
	output logic [7:0]  temperature_c,
	output logic [15:0] voltage_word,
	output logic [15:0] current_word,
	output logic [15:0] consumed_mah,
	output logic [15:0] erpm_word,
	output logic [3:0]  bytes_received,
	output logic [15:0] discarded_total
);
	import esc_tfd_pkg::*;

	logic              valid_s1;
	logic [1:0]        req_s1;
	logic [7:0]        byte_s1;
	logic              out_valid_q;
	result_t           res_q;
	logic [TICK_W-1:0] timeout_ticks;
	logic              core_res_valid;
	result_t           core_res;
	logic              out_free;
	logic              advance;

	esc_tfd_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.timeout_ticks (timeout_ticks)
	);

	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (out_free || !core_res_valid);
	assign in_ready = !valid_s1 || advance;

	// Input stage: capture a beat whenever the stage empties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1  <= req_type;
			byte_s1 <= rx_byte;
		end
	end

	esc_tfd_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.req_type      (req_s1),
		.rx_byte       (byte_s1),
		.timeout_ticks (timeout_ticks),
		.res_valid     (core_res_valid),
		.res           (core_res)
	);

	// Result register: load a new result, drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && core_res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && core_res_valid) begin
			res_q <= core_res;
		end
	end

	assign out_valid       = out_valid_q;
	assign frame_status    = res_q.frame_status;
	assign temperature_c   = res_q.temperature_c;
	assign voltage_word    = res_q.voltage_word;
	assign current_word    = res_q.current_word;
	assign consumed_mah    = res_q.consumed_mah;
	assign erpm_word       = res_q.erpm_word;
	assign bytes_received  = res_q.bytes_received;
	assign discarded_total = res_q.discarded_total;

endmodule
